[rtl/tlq_pkg.sv]
package tlq_pkg;

    localparam int COORD_W     = 16;
    localparam int LENS_W      = 12;
    localparam int WIDTH_SHIFT = 7;
    localparam int HW_NUM_W    = COORD_W + WIDTH_SHIFT;   // width << 7
    localparam int HW_DEN_W    = COORD_W + 1;             // lens + depth
    localparam int LEN_W       = 17;                      // segment length
    localparam int SUMSQ_W     = 33;                      // dx^2 + dy^2
    localparam int RAD_W       = 34;                      // padded to even width
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int OFS_W       = COORD_W + HW_NUM_W;      // |d| * half-width
    localparam int CFG_W       = LENS_W;

    localparam logic [LENS_W-1:0] LENS_RESET = 12'd420;

    typedef enum logic
    {
        CFG_LENGTH_MODE = 1'b0,
        CFG_LENS_OFFSET = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic        [COORD_W-1:0] start_depth;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic        [COORD_W-1:0] end_depth;
        logic        [COORD_W-1:0] start_width;
        logic        [COORD_W-1:0] end_width;
    } in_item_t;

    typedef struct packed
    {
        logic signed [COORD_W-1:0] corner_a_x;
        logic signed [COORD_W-1:0] corner_a_y;
        logic signed [COORD_W-1:0] corner_b_x;
        logic signed [COORD_W-1:0] corner_b_y;
        logic signed [COORD_W-1:0] corner_c_x;
        logic signed [COORD_W-1:0] corner_c_y;
        logic signed [COORD_W-1:0] corner_d_x;
        logic signed [COORD_W-1:0] corner_d_y;
    } out_item_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic               dx_neg;
        logic               dy_neg;
        logic [LEN_W-1:0]   oct_len;
    } carry_t;

endpackage

[rtl/tlq_stream_if.sv]
interface tlq_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tlq_div_cell.sv]
module tlq_div_cell #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] r_in,
    input  logic [NW-1:0] q_in,
    input  logic [DW-1:0] d_in,
    output logic [DW-1:0] r_out,
    output logic [NW-1:0] q_out,
    output logic [DW-1:0] d_out
);
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] r_reg, r_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] d_reg;

    always_comb
    begin
        t      = {r_in, q_in[NW-1]};
        diff   = t - {1'b0, d_in};
        ge     = (t >= {1'b0, d_in});
        r_next = ge ? diff[DW-1:0] : t[DW-1:0];
        q_next = {q_in[NW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            d_reg <= d_in;
        end
    end

    assign r_out = r_reg;
    assign q_out = q_reg;
    assign d_out = d_reg;
endmodule

[rtl/tlq_div.sv]
module tlq_div #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] den_out
);
    logic [DW-1:0] r_w [0:NW];
    logic [NW-1:0] q_w [0:NW];
    logic [DW-1:0] d_w [0:NW];

    assign r_w[0] = '0;
    assign q_w[0] = num;
    assign d_w[0] = den;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        tlq_div_cell #(.NW(NW), .DW(DW)) u_cell (
            .clk   (clk),
            .en    (en),
            .r_in  (r_w[i]),
            .q_in  (q_w[i]),
            .d_in  (d_w[i]),
            .r_out (r_w[i+1]),
            .q_out (q_w[i+1]),
            .d_out (d_w[i+1])
        );
    end

    assign quo     = q_w[NW];
    assign den_out = d_w[NW];
endmodule

[rtl/tlq_sqrt.sv]
module tlq_sqrt
    import tlq_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [SUMSQ_W-1:0] rad,
    output logic [ROOT_W-1:0]  root
);
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [RAD_W-1:0]  n_reg    [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_cell
        logic [REM_W-1:0]  rem_p;
        logic [ROOT_W-1:0] root_p;
        logic [RAD_W-1:0]  n_p;
        logic [REM_W+1:0]  x;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign n_p    = {{(RAD_W-SUMSQ_W){1'b0}}, rad};
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign n_p    = n_reg[k-1];
        end

        always_comb
        begin
            x     = {rem_p, n_p[RAD_W-1 -: 2]};
            trial = {1'b0, root_p, 2'b01};
            diff  = x - trial;
            ge    = (x >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : x[REM_W-1:0];
                root_reg[k] <= {root_p[ROOT_W-2:0], ge};
                n_reg[k]    <= {n_p[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ROOT_W-1];
endmodule

[rtl/thick_line_quad_setup.sv]
// Throughput: one segment per cycle while the output is not blocked; each divider and root
// cell is its own stage. Latency is set by a 23-cell half-width divider chain and 39-cell
// offset chains (62 cells in all).
// Zero-length segments leave the pipeline without producing a result.
// Reset clears all valid flags and sets length_mode to 0 and lens_offset to 420;
// datapath registers are not reset.
module thick_line_quad_setup
    import tlq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tlq_stream_if.sink        in_ch,
    tlq_stream_if.source      out_ch,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);
    localparam int HW_LAT  = HW_NUM_W;
    localparam int SQ_LAT  = 2 + ROOT_W;
    localparam int LEN_DLY = HW_LAT - SQ_LAT;
    localparam int LAST    = HW_LAT + 1 + OFS_W;

    logic              length_mode_reg;
    logic [LENS_W-1:0] lens_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_mode_reg <= 1'b0;
            lens_offset_reg <= LENS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LENGTH_MODE: length_mode_reg <= cfg_data[0];
                CFG_LENS_OFFSET: lens_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic va_reg;
    logic v_reg [0:LAST];
    in_item_t a_reg;
    logic out_valid_reg;
    out_item_t out_data_reg;

    assign adv         = !v_reg[LAST] || !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk)
    begin
        if (adv)
            a_reg <= in_ch.data;
    end

    // stage 0: deltas, octagonal length, half-width divider operands
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0]        adx, ady;
    logic [COORD_W-1:0]      ax, ay;
    logic [LEN_W-1:0]        oct;
    logic [HW_DEN_W-1:0]     den1, den2;
    carry_t                  car_next;

    always_comb
    begin
        dx   = {a_reg.end_x[COORD_W-1], a_reg.end_x} - {a_reg.start_x[COORD_W-1], a_reg.start_x};
        dy   = {a_reg.end_y[COORD_W-1], a_reg.end_y} - {a_reg.start_y[COORD_W-1], a_reg.start_y};
        adx  = dx[COORD_W] ? -dx : dx;
        ady  = dy[COORD_W] ? -dy : dy;
        ax   = adx[COORD_W-1:0];
        ay   = ady[COORD_W-1:0];
        oct  = (ax > ay) ? {1'b0, ax} + {2'b00, ay[COORD_W-1:1]}
                         : {1'b0, ay} + {2'b00, ax[COORD_W-1:1]};
        den1 = {{(HW_DEN_W-LENS_W){1'b0}}, lens_offset_reg} + {1'b0, a_reg.start_depth};
        den2 = {{(HW_DEN_W-LENS_W){1'b0}}, lens_offset_reg} + {1'b0, a_reg.end_depth};
        car_next.sx      = a_reg.start_x;
        car_next.sy      = a_reg.start_y;
        car_next.ex      = a_reg.end_x;
        car_next.ey      = a_reg.end_y;
        car_next.ax      = ax;
        car_next.ay      = ay;
        car_next.dx_neg  = dx[COORD_W];
        car_next.dy_neg  = dy[COORD_W];
        car_next.oct_len = oct;
    end

    carry_t              car_reg [0:LAST];
    logic [HW_NUM_W-1:0] hn1_reg, hn2_reg;
    logic [HW_DEN_W-1:0] hd1_reg, hd2_reg;

    // a zero divisor gives a zero half-width
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            car_reg[0] <= car_next;
            hn1_reg    <= (den1 == '0) ? '0 : {a_reg.start_width, {WIDTH_SHIFT{1'b0}}};
            hn2_reg    <= (den2 == '0) ? '0 : {a_reg.end_width, {WIDTH_SHIFT{1'b0}}};
            hd1_reg    <= (den1 == '0) ? HW_DEN_W'(1) : den1;
            hd2_reg    <= (den2 == '0) ? HW_DEN_W'(1) : den2;
        end
    end

    for (genvar i = 1; i <= LAST; i++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (adv)
                car_reg[i] <= car_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= in_ch.valid;
    end

    for (genvar i = 0; i <= LAST; i++)
    begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (adv)
                v_reg[i] <= (i == 0) ? va_reg : v_reg[(i == 0) ? 0 : i-1];
        end
    end

    // squared length and square root
    logic [2*COORD_W-1:0] sqx_reg, sqy_reg;
    logic [SUMSQ_W-1:0]   sum_reg;
    logic [ROOT_W-1:0]    root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= car_reg[0].ax * car_reg[0].ax;
            sqy_reg <= car_reg[0].ay * car_reg[0].ay;
            sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    tlq_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sum_reg),
        .root (root)
    );

    logic [LEN_W-1:0] len_d_reg [0:LEN_DLY-1];

    always_ff @(posedge clk)
    begin
        if (adv)
            len_d_reg[0] <= length_mode_reg ? LEN_W'(root) : car_reg[SQ_LAT].oct_len;
    end

    for (genvar i = 1; i < LEN_DLY; i++)
    begin : g_len
        always_ff @(posedge clk)
        begin
            if (adv)
                len_d_reg[i] <= len_d_reg[i-1];
        end
    end

    // half-width dividers
    logic [HW_NUM_W-1:0] hw1, hw2;
    logic [HW_DEN_W-1:0] hd1_out, hd2_out;

    tlq_div #(.NW(HW_NUM_W), .DW(HW_DEN_W)) u_hw1 (
        .clk (clk), .en (adv), .num (hn1_reg), .den (hd1_reg),
        .quo (hw1), .den_out (hd1_out)
    );

    tlq_div #(.NW(HW_NUM_W), .DW(HW_DEN_W)) u_hw2 (
        .clk (clk), .en (adv), .num (hn2_reg), .den (hd2_reg),
        .quo (hw2), .den_out (hd2_out)
    );

    // offset magnitudes
    logic [OFS_W-1:0] pox1_reg, poy1_reg, pox2_reg, poy2_reg;
    logic [LEN_W-1:0] pl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pox1_reg <= car_reg[HW_LAT].ay * hw1;
            poy1_reg <= car_reg[HW_LAT].ax * hw1;
            pox2_reg <= car_reg[HW_LAT].ay * hw2;
            poy2_reg <= car_reg[HW_LAT].ax * hw2;
            pl_reg   <= len_d_reg[LEN_DLY-1];
        end
    end

    logic [OFS_W-1:0] qx1, qy1, qx2, qy2;
    logic [LEN_W-1:0] lx1, ly1, lx2, ly2;

    tlq_div #(.NW(OFS_W), .DW(LEN_W)) u_ox1 (
        .clk (clk), .en (adv), .num (pox1_reg), .den (pl_reg), .quo (qx1), .den_out (lx1)
    );
    tlq_div #(.NW(OFS_W), .DW(LEN_W)) u_oy1 (
        .clk (clk), .en (adv), .num (poy1_reg), .den (pl_reg), .quo (qy1), .den_out (ly1)
    );
    tlq_div #(.NW(OFS_W), .DW(LEN_W)) u_ox2 (
        .clk (clk), .en (adv), .num (pox2_reg), .den (pl_reg), .quo (qx2), .den_out (lx2)
    );
    tlq_div #(.NW(OFS_W), .DW(LEN_W)) u_oy2 (
        .clk (clk), .en (adv), .num (poy2_reg), .den (pl_reg), .quo (qy2), .den_out (ly2)
    );

    // corners
    logic [COORD_W-1:0] ox1, oy1, ox2, oy2;
    logic               len_nz;
    out_item_t          out_next;
    carry_t             cl;

    always_comb
    begin
        cl     = car_reg[LAST];
        // x offset takes the sign of -dy, y offset the sign of dx
        ox1    = !cl.dy_neg ? -qx1[COORD_W-1:0] : qx1[COORD_W-1:0];
        ox2    = !cl.dy_neg ? -qx2[COORD_W-1:0] : qx2[COORD_W-1:0];
        oy1    = cl.dx_neg ? -qy1[COORD_W-1:0] : qy1[COORD_W-1:0];
        oy2    = cl.dx_neg ? -qy2[COORD_W-1:0] : qy2[COORD_W-1:0];
        len_nz = (lx1 != '0);
        out_next.corner_a_x = cl.sx + ox1;
        out_next.corner_a_y = cl.sy + oy1;
        out_next.corner_b_x = cl.sx - ox1;
        out_next.corner_b_y = cl.sy - oy1;
        out_next.corner_c_x = cl.ex + ox2;
        out_next.corner_c_y = cl.ey + oy2;
        out_next.corner_d_x = cl.ex - ox2;
        out_next.corner_d_y = cl.ey - oy2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ch.ready)
            out_valid_reg <= v_reg[LAST] && len_nz;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ch.ready)
            out_data_reg <= out_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready && v_reg[LAST]))
        else $error("input stalled without a blocked result");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v_reg[LAST]))
        else $error("result appeared with no item at the pipe end");

    a_stalled_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && !adv) |=> v_reg[LAST])
        else $error("item lost at the pipe end during a stall");

    a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] |-> (lx1 == lx2 && ly1 == ly2 && lx1 == ly1))
        else $error("offset divider chains out of step");

    logic unused_ok;
    assign unused_ok = ^{hd1_out, hd2_out};
endmodule
